// ===== sv/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token kind codes and character class helpers for the
// source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int unsigned MAX_TEXT_LENGTH_DEF = 65536;
    localparam int unsigned OUTQ_DEPTH          = 4;

    localparam logic [3:0] KIND_INT    = 4'd0;
    localparam logic [3:0] KIND_IDENT  = 4'd1;
    localparam logic [3:0] KIND_RETURN = 4'd2;
    localparam logic [3:0] KIND_LBRACE = 4'd3;
    localparam logic [3:0] KIND_RBRACE = 4'd4;
    localparam logic [3:0] KIND_LPAREN = 4'd5;
    localparam logic [3:0] KIND_RPAREN = 4'd6;
    localparam logic [3:0] KIND_SEMI   = 4'd7;
    localparam logic [3:0] KIND_MINUS  = 4'd8;
    localparam logic [3:0] KIND_TILDE  = 4'd9;
    localparam logic [3:0] KIND_BANG   = 4'd10;
    localparam logic [3:0] KIND_PLUS   = 4'd11;
    localparam logic [3:0] KIND_STAR   = 4'd12;
    localparam logic [3:0] KIND_SLASH  = 4'd13;
    localparam logic [3:0] KIND_EOF    = 4'd14;
    localparam logic [3:0] KIND_ERROR  = 4'd15;

    localparam logic [2:0] KEYWORD_LEN = 3'd6;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] int_value;
        logic [15:0] ident_offset;
        logic [15:0] ident_length;
        logic [15:0] line_number;
        logic        last;
    } result_t;

    // Up to two results produced by one input byte, already compacted:
    // when only one exists it sits in slot 0.
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } result_pair_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == 8'h5F);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h09);
    endfunction

    // Punctuator kind, or KIND_INT when the byte is not a punctuator.
    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h3B:   k = KIND_SEMI;
            8'h2D:   k = KIND_MINUS;
            8'h7E:   k = KIND_TILDE;
            8'h21:   k = KIND_BANG;
            8'h2B:   k = KIND_PLUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            default: k = KIND_INT;
        endcase
        return k;
    endfunction

    // Characters of the keyword "return" by position.
    function automatic logic [7:0] keyword_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h72;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h75;
            3'd4:    c = 8'h72;
            3'd5:    c = 8'h6E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Byte-at-a-time lexer: integers, identifiers, the keyword return,
// punctuators, end of text and error tokens.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  -------  ---------  ---------------------------------------------------------
//  s_*      in         tdata: ch; tlast: end_of_text
//  m_*      out        tdata: int_value, ident_offset, ident_length,
//                      line_number; tuser: kind; tlast: last of a byte's results
//
// One byte transaction is taken per cycle while the queue has room. Each
// byte updates the scanner state in the cycle it is accepted and pushes
// zero, one or two tokens into a four-entry result queue; tokens leave the
// queue at one per cycle while m_tready is high. The input side stalls only
// while fewer than two queue entries are free, so the output rate of one
// token per cycle sets the throughput. Reset (asynchronous, active low)
// returns the scanner to line 1, offset 0.
module source_text_tokenizer #(
    parameter int unsigned MAX_TEXT_LENGTH = stt_pkg::MAX_TEXT_LENGTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] ch
    input  logic         s_tlast,   // end_of_text

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // [63:0] int_value, [79:64] ident_offset,
                                    // [95:80] ident_length, [111:96] line_number
    output logic [3:0]   m_tuser,   // [3:0] kind
    output logic         m_tlast    // last token caused by an input transaction
);
    import stt_pkg::*;

    logic         step;
    logic         room;
    result_pair_t results;
    result_t      head;

    // A transaction is taken whenever the queue can absorb its worst case.
    assign s_tready = room;
    assign step     = s_tvalid && room;

    stt_core #(
        .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .ch          (s_tdata),
        .end_of_text (s_tlast),
        .results     (results)
    );

    stt_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (results),
        .room       (room),
        .head       (head),
        .head_valid (m_tvalid),
        .pop_ready  (m_tready)
    );

    // Pack the queue head onto the master stream.
    assign m_tdata = {head.line_number, head.ident_length, head.ident_offset,
                      head.int_value};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

// ===== sv/stt_core.sv =====
// ----------------------------------------------------------------------------
// stt_core
// Scanner state and the per-byte update; emits up to two results per byte.
// ----------------------------------------------------------------------------
module stt_core #(
    parameter int unsigned MAX_TEXT_LENGTH = stt_pkg::MAX_TEXT_LENGTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           ch,
    input  logic                 end_of_text,
    output stt_pkg::result_pair_t results
);
    import stt_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_TEXT_LENGTH);

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_INT   = 2'd1;
    localparam logic [1:0] MODE_IDENT = 2'd2;
    localparam logic [1:0] MODE_ERROR = 2'd3;

    logic [1:0]       mode_reg, mode_next;
    logic [63:0]      acc_reg, acc_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [2:0]       kw_prog_reg, kw_prog_next;
    logic             kw_alive_reg, kw_alive_next;
    logic [15:0]      line_reg, line_next;

    logic [POS_W-1:0]  pos_inc;
    logic [POS_W:0]    diff;
    logic [POS_W:0]    diff_wrap;
    logic [POS_W-1:0]  ident_len;
    logic [POS_W+15:0] len_ext;
    logic [POS_W+15:0] start_ext;
    logic              kw_match;
    logic              kw_first;
    logic              is_return;
    logic              take_new;
    logic              flush_v;
    logic              second_v;
    result_t           flush_res;
    result_t           second_res;

    assign pos_inc = (pos_reg == POS_W'(MAX_TEXT_LENGTH - 1)) ? '0 : pos_reg + 1'b1;

    // Identifier length, taken modulo the text length.
    assign diff      = {1'b0, pos_reg} - {1'b0, start_reg};
    assign diff_wrap = diff + (POS_W + 1)'(MAX_TEXT_LENGTH);
    assign ident_len = (pos_reg >= start_reg) ? diff[POS_W-1:0] : diff_wrap[POS_W-1:0];
    assign len_ext   = {16'b0, ident_len};
    assign start_ext = {16'b0, start_reg};

    assign kw_match  = kw_alive_reg && (kw_prog_reg < KEYWORD_LEN)
                    && (ch == keyword_char(kw_prog_reg));
    assign kw_first  = (ch == keyword_char(3'd0));
    assign is_return = kw_alive_reg && (kw_prog_reg == KEYWORD_LEN);

    always_comb
    begin
        flush_res              = '0;
        flush_res.line_number  = line_reg;
        if (mode_reg == MODE_INT)
        begin
            flush_res.kind      = KIND_INT;
            flush_res.int_value = acc_reg;
        end
        else if (is_return)
        begin
            flush_res.kind = KIND_RETURN;
        end
        else
        begin
            flush_res.kind         = KIND_IDENT;
            flush_res.ident_offset = start_ext[15:0];
            flush_res.ident_length = len_ext[15:0];
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        acc_next      = acc_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        kw_prog_next  = kw_prog_reg;
        kw_alive_next = kw_alive_reg;
        line_next     = line_reg;
        take_new      = 1'b0;
        flush_v       = 1'b0;
        second_v      = 1'b0;
        second_res             = '0;
        second_res.line_number = line_reg;

        if (step)
        begin
            if (end_of_text)
            begin
                flush_v         = (mode_reg == MODE_INT) || (mode_reg == MODE_IDENT);
                second_v        = 1'b1;
                second_res.kind = KIND_EOF;
                mode_next       = MODE_IDLE;
                acc_next        = '0;
                pos_next        = '0;
                start_next      = '0;
                kw_prog_next    = '0;
                kw_alive_next   = 1'b1;
                line_next       = 16'd1;
            end
            else
            begin
                case (mode_reg)
                    MODE_INT:
                    begin
                        if (is_digit(ch))
                        begin
                            acc_next = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0}
                                     + {60'd0, ch[3:0]};
                            pos_next = pos_inc;
                        end
                        else
                        begin
                            flush_v  = 1'b1;
                            take_new = 1'b1;
                        end
                    end
                    MODE_IDENT:
                    begin
                        if (is_letter(ch) || is_digit(ch))
                        begin
                            if (kw_match)
                                kw_prog_next = kw_prog_reg + 3'd1;
                            else
                                kw_alive_next = 1'b0;
                            pos_next = pos_inc;
                        end
                        else
                        begin
                            flush_v  = 1'b1;
                            take_new = 1'b1;
                        end
                    end
                    MODE_IDLE:
                    begin
                        take_new = 1'b1;
                    end
                    default:
                    begin
                        // Error mode swallows everything until the end marker.
                    end
                endcase

                if (take_new)
                begin
                    mode_next = MODE_IDLE;
                    pos_next  = pos_inc;
                    if (is_space(ch))
                    begin
                        if ((ch == 8'h0A) && (line_reg != 16'hFFFF))
                            line_next = line_reg + 16'd1;
                    end
                    else if (is_digit(ch))
                    begin
                        mode_next = MODE_INT;
                        acc_next  = {60'd0, ch[3:0]};
                    end
                    else if (is_letter(ch))
                    begin
                        mode_next     = MODE_IDENT;
                        start_next    = pos_reg;
                        kw_prog_next  = kw_first ? 3'd1 : 3'd0;
                        kw_alive_next = kw_first;
                    end
                    else
                    begin
                        second_v = 1'b1;
                        if (punct_kind(ch) != KIND_INT)
                        begin
                            second_res.kind = punct_kind(ch);
                        end
                        else
                        begin
                            second_res.kind = KIND_ERROR;
                            mode_next       = MODE_ERROR;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        results.v0      = flush_v || second_v;
        results.v1      = flush_v && second_v;
        results.r0      = flush_v ? flush_res : second_res;
        results.r0.last = !(flush_v && second_v);
        results.r1      = second_res;
        results.r1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            acc_reg      <= '0;
            pos_reg      <= '0;
            start_reg    <= '0;
            kw_prog_reg  <= '0;
            kw_alive_reg <= 1'b1;
            line_reg     <= 16'd1;
        end
        else
        begin
            mode_reg     <= mode_next;
            acc_reg      <= acc_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            kw_prog_reg  <= kw_prog_next;
            kw_alive_reg <= kw_alive_next;
            line_reg     <= line_next;
        end
    end

endmodule

// ===== sv/stt_outq.sv =====
// ----------------------------------------------------------------------------
// stt_outq
// Small result queue: takes up to two results per cycle, hands out one while pop_ready is high.
// ----------------------------------------------------------------------------
module stt_outq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stt_pkg::result_pair_t wr,
    output logic                  room,
    output stt_pkg::result_t      head,
    output logic                  head_valid,
    input  logic                  pop_ready
);
    import stt_pkg::*;

    localparam int unsigned QW = $clog2(OUTQ_DEPTH);

    result_t       mem [OUTQ_DEPTH];
    logic [QW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QW:0]   count_reg, count_next;
    logic          pop;

    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;
    // Accept only with room for the worst case of two results.
    assign room       = (count_reg <= (QW + 1)'(OUTQ_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + {{(QW - 1){1'b0}}, wr.v0} + {{(QW - 1){1'b0}}, wr.v1};
        rd_ptr_next = rd_ptr_reg + {{(QW - 1){1'b0}}, pop};
        count_next  = count_reg + {{QW{1'b0}}, wr.v0} + {{QW{1'b0}}, wr.v1}
                    - {{QW{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (wr.v0)
            mem[wr_ptr_reg] <= wr.r0;
        if (wr.v1)
            mem[wr_ptr_reg + 1'b1] <= wr.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer testbench
// Feeds byte streams into the tokenizer and predicts the token stream that
// each byte transaction should produce. Every output transaction is compared
// field by field against the oldest predicted token. The run has a short
// directed text and four phases of random texts under varying idle and
// stall pressure.
// ----------------------------------------------------------------------------
module testbench;

    // Scanner modes of the predictor.
    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_INT,
        SCAN_IDENT,
        SCAN_ERROR
    } scan_mode_e;

    // The keyword, first character in the top byte.
    localparam logic [47:0] RETURN_WORD = "return";

    // ------------------------------------------------------------------------
    // Scoreboard: owns a private copy of the scanner state, turns every
    // accepted byte transaction into the tokens it must cause, and checks the
    // tokens that leave the block against them in order.
    // ------------------------------------------------------------------------
    class token_scoreboard;
        scan_mode_e        mode;
        logic [63:0]       acc;
        logic [15:0]       pos;
        logic [15:0]       start;
        logic [15:0]       line;
        logic [2:0]        kw_matched;
        logic              kw_possible;
        stt_pkg::result_t  expected_tokens[$];
        int unsigned       mismatches;
        int unsigned       tokens_seen;
        int unsigned       bytes_taken;
        int unsigned       texts;
        int unsigned       error_tokens;

        function new();
            restart();
            mismatches   = 0;
            tokens_seen  = 0;
            bytes_taken  = 0;
            texts        = 0;
            error_tokens = 0;
        endfunction

        function void restart();
            mode        = SCAN_IDLE;
            acc         = '0;
            pos         = '0;
            start       = '0;
            kw_matched  = '0;
            kw_possible = 1'b1;
            line        = 16'd1;
        endfunction

        function bit is_decimal(logic [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        function bit starts_word(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
        endfunction

        function bit punct_token(input logic [7:0] c, output logic [3:0] k);
            bit found;
            found = 1'b1;
            case (c)
                8'h7B:   k = stt_pkg::KIND_LBRACE;
                8'h7D:   k = stt_pkg::KIND_RBRACE;
                8'h28:   k = stt_pkg::KIND_LPAREN;
                8'h29:   k = stt_pkg::KIND_RPAREN;
                8'h3B:   k = stt_pkg::KIND_SEMI;
                8'h2D:   k = stt_pkg::KIND_MINUS;
                8'h7E:   k = stt_pkg::KIND_TILDE;
                8'h21:   k = stt_pkg::KIND_BANG;
                8'h2B:   k = stt_pkg::KIND_PLUS;
                8'h2A:   k = stt_pkg::KIND_STAR;
                8'h2F:   k = stt_pkg::KIND_SLASH;
                default:
                begin
                    k     = stt_pkg::KIND_ERROR;
                    found = 1'b0;
                end
            endcase
            return found;
        endfunction

        function bit legal_byte(logic [7:0] c);
            logic [3:0] k;
            return is_blank(c) || is_decimal(c) || starts_word(c) || punct_token(c, k);
        endfunction

        function void add_token(logic [3:0] kind, logic [63:0] value,
                                logic [15:0] offset, logic [15:0] length);
            stt_pkg::result_t t;
            t.kind         = kind;
            t.int_value    = value;
            t.ident_offset = offset;
            t.ident_length = length;
            t.line_number  = line;
            t.last         = 1'b0;
            expected_tokens.push_back(t);
        endfunction

        // Emits the integer or identifier under construction, if any.
        function void close_token();
            logic [15:0] length;
            length = pos - start;
            if (mode == SCAN_INT)
                add_token(stt_pkg::KIND_INT, acc, 16'd0, 16'd0);
            else if (mode == SCAN_IDENT)
            begin
                if (kw_possible && kw_matched == stt_pkg::KEYWORD_LEN)
                    add_token(stt_pkg::KIND_RETURN, 64'd0, 16'd0, 16'd0);
                else
                    add_token(stt_pkg::KIND_IDENT, 64'd0, start, length);
            end
            if (mode != SCAN_ERROR)
                mode = SCAN_IDLE;
        endfunction

        function void track_keyword(logic [7:0] c);
            if (kw_possible && kw_matched < stt_pkg::KEYWORD_LEN
                && c == RETURN_WORD[47 - 8 * int'(kw_matched) -: 8])
                kw_matched = kw_matched + 3'd1;
            else
                kw_possible = 1'b0;
        endfunction

        // Predicts the tokens caused by one accepted byte transaction.
        function void note_byte(logic [7:0] c, logic eot);
            int unsigned queued_at_entry;
            logic [3:0]  pk;
            queued_at_entry = expected_tokens.size();
            bytes_taken++;
            if (eot)
            begin
                close_token();
                add_token(stt_pkg::KIND_EOF, 64'd0, 16'd0, 16'd0);
                texts++;
                restart();
            end
            else if (mode != SCAN_ERROR)
            begin
                if (mode == SCAN_INT && is_decimal(c))
                begin
                    acc = acc * 64'd10 + {56'd0, c - 8'h30};
                    pos = pos + 16'd1;
                end
                else if (mode == SCAN_IDENT && (starts_word(c) || is_decimal(c)))
                begin
                    track_keyword(c);
                    pos = pos + 16'd1;
                end
                else
                begin
                    close_token();
                    if (is_blank(c))
                    begin
                        if (c == 8'h0A && line != 16'hFFFF)
                            line = line + 16'd1;
                    end
                    else if (is_decimal(c))
                    begin
                        mode = SCAN_INT;
                        acc  = {56'd0, c - 8'h30};
                    end
                    else if (starts_word(c))
                    begin
                        mode        = SCAN_IDENT;
                        start       = pos;
                        kw_matched  = 3'd0;
                        kw_possible = 1'b1;
                        track_keyword(c);
                    end
                    else if (punct_token(c, pk))
                        add_token(pk, 64'd0, 16'd0, 16'd0);
                    else
                    begin
                        add_token(stt_pkg::KIND_ERROR, 64'd0, 16'd0, 16'd0);
                        mode = SCAN_ERROR;
                        error_tokens++;
                    end
                    pos = pos + 16'd1;
                end
            end
            if (expected_tokens.size() > queued_at_entry)
                expected_tokens[expected_tokens.size() - 1].last = 1'b1;
        endfunction

        function void report(string why, stt_pkg::result_t want, stt_pkg::result_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t mismatch (%s):", $realtime, why);
                $display("  exp kind %0d val %0h off %0d len %0d line %0d last %0b",
                         want.kind, want.int_value, want.ident_offset, want.ident_length,
                         want.line_number, want.last);
                $display("  act kind %0d val %0h off %0d len %0d line %0d last %0b",
                         got.kind, got.int_value, got.ident_offset, got.ident_length,
                         got.line_number, got.last);
            end
        endfunction

        // Compares one output transaction with the oldest predicted token.
        function void check_token(logic [3:0] kind, logic [111:0] data, logic last);
            stt_pkg::result_t want;
            stt_pkg::result_t got;
            string            bad;
            got.kind         = kind;
            got.int_value    = data[63:0];
            got.ident_offset = data[79:64];
            got.ident_length = data[95:80];
            got.line_number  = data[111:96];
            got.last         = last;
            tokens_seen++;
            if (expected_tokens.size() == 0)
            begin
                want = '0;
                report("no token was due", want, got);
                return;
            end
            want = expected_tokens.pop_front();
            bad  = "";
            if (got.kind !== want.kind)                 bad = {bad, " kind"};
            if (got.int_value !== want.int_value)       bad = {bad, " int_value"};
            if (got.ident_offset !== want.ident_offset) bad = {bad, " ident_offset"};
            if (got.ident_length !== want.ident_length) bad = {bad, " ident_length"};
            if (got.line_number !== want.line_number)   bad = {bad, " line_number"};
            if (got.last !== want.last)                 bad = {bad, " last"};
            if (bad != "")
                report({"field", bad}, want, got);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block interface.
    // ------------------------------------------------------------------------
    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;

    // Percent of cycles in which the sender idles and the receiver stalls.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    // Cycles of forced receiver hold-off still to run.
    int unsigned hold_left      = 0;

    // Character sets for the random text generator. Letters and the
    // underscore come first so that the head of the set starts a word.
    string WORD_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string PUNCT_SET  = "{}();-~!+*/";
    string BLANK_SET  = " \n\r\t";

    token_scoreboard sb = new();

    always #6 clk = ~clk;

    source_text_tokenizer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Receiver: random back-pressure, plus a forced hold-off that it counts
    // down itself once the stimulus asks for one.
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Output monitor. Values are read at the edge, before any of this edge's
    // updates land, so each accepted transaction is seen exactly once.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_token(m_tuser, m_tdata, m_tlast);
    end

    // ------------------------------------------------------------------------
    // Driver tasks.
    // ------------------------------------------------------------------------

    // Offers one byte transaction and returns at the edge that accepts it.
    // The valid is left high so the next call can follow without a bubble;
    // it is only lowered by an idle cycle or by a drain.
    task automatic send_item(input logic [7:0] c, input logic eot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(255));
            s_tlast  <= 1'($urandom_range(1));
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(c, eot);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_word_char();
        return WORD_CHARS[$urandom_range(WORD_CHARS.len() - 1)];
    endfunction

    // Stops offering and waits until every predicted token has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_number();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(19);
        if (pick == 0)
            send_string("18446744073709551615");     // largest 64-bit value
        else if (pick == 1)
            send_string("18446744073709551616");     // wraps to zero
        else
        begin
            len = (pick < 4) ? $urandom_range(24, 19) : $urandom_range(4, 1);
            repeat (len) send_item(8'h30 + 8'($urandom_range(9)), 1'b0);
        end
    endtask

    task automatic send_word();
        string       kw;
        int unsigned pick;
        kw   = "return";
        pick = $urandom_range(9);
        case (pick)
            0, 1: send_string(kw);
            2:    send_string(kw.substr(0, $urandom_range(4)));
            3:
            begin
                send_string(kw);
                send_item(pick_word_char(), 1'b0);
            end
            4:    send_string(($urandom_range(1) == 0) ? "Return" : "retUrn");
            default:
            begin
                // Random word: first character must start an identifier.
                send_item(WORD_CHARS[$urandom_range(52)], 1'b0);
                repeat ($urandom_range(7)) send_item(pick_word_char(), 1'b0);
            end
        endcase
    endtask

    // Sends one text: mostly well-formed tokens run together, sometimes an
    // illegal byte followed by junk, and always closed by an end marker.
    task automatic send_text(input int unsigned n_tokens);
        int unsigned pick;
        logic [7:0]  c;
        for (int unsigned i = 0; i < n_tokens; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
                send_number();
            else if (pick < 50)
                send_word();
            else if (pick < 75)
                send_item(PUNCT_SET[$urandom_range(PUNCT_SET.len() - 1)], 1'b0);
            else if (pick < 92)
                repeat ($urandom_range(3, 1))
                    send_item(BLANK_SET[$urandom_range(BLANK_SET.len() - 1)], 1'b0);
            else if (pick < 97)
            begin
                // Illegal byte: the block reports it and then ignores the rest.
                if ($urandom_range(2) == 0)
                    c = ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
                else
                    do
                        c = 8'($urandom_range(255));
                    while (sb.legal_byte(c));
                send_item(c, 1'b0);
                repeat ($urandom_range(6)) send_item(8'($urandom_range(255)), 1'b0);
                break;
            end
            else
                send_item(8'($urandom_range(255)), 1'b0);
        end
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned phase_start;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed text: the keyword, a letter right after a digit, every
        // punctuator, blanks, a digit inside an identifier, and an end
        // marker that flushes that identifier.
        send_string("return;7q{}()-~!+*/\n\t_9");
        send_item(8'hA5, 1'b1);
        // Error on the zero byte; the all-ones byte after it is ignored and
        // the end marker then gives only the end token.
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h5A, 1'b1);
        drain();

        // Random texts under four pressure settings. Each drain between the
        // phases leaves the sender paused until all tokens have arrived.
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                    // Long receiver hold-off so the result queue fills and
                    // the input side has to stall.
                    hold_left      = 300;
                end
                default:
                begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
            endcase
            phase_start = sb.bytes_taken;
            while (sb.bytes_taken - phase_start < 110)
                send_text($urandom_range(30, 3));
            drain();
        end

        recv_stall_pct = 0;
        drain();
        repeat (20) @(posedge clk);

        $display("Run covered %0d byte transactions in %0d texts, %0d ending in an error.",
                 sb.bytes_taken, sb.texts, sb.error_tokens);
        $display("%0d tokens compared, %0d mismatched, %0d still outstanding.",
                 sb.tokens_seen, sb.mismatches, sb.expected_tokens.size());
        if (sb.mismatches == 0 && sb.expected_tokens.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run.
    initial
    begin : watchdog
        #(64'd10_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
